[rtl/dtt_pkg.sv]
package dtt_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam int REQ_W  = 3;
  localparam int ID_W   = 4;
  localparam int SEC_W  = 31;
  localparam int USEC_W = 20;
  localparam int KIND_W = 3;
  localparam int DL_W   = SEC_W + USEC_W;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
  localparam logic [USEC_W-1:0] USEC_MAX     = USEC_W'(999999);
  localparam logic [SEC_W-1:0]  SEC_MAX      = SEC_W'(32'h7fffffff);

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CHECK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMAIN = 3'd4;

  // response kinds
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WAIT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  function automatic logic [USEC_W-1:0] clamp_usec(input logic [USEC_W-1:0] v);
    return (v > USEC_MAX) ? USEC_MAX : v;
  endfunction

endpackage

[rtl/dtt_ram.sv]
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/deadline_timer_table.sv]
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_stall  req_type timer_id now_sec now_usec
//                                           interval_sec interval_usec
// response  out        resp_valid/resp_stall resp_kind slot_id time_sec time_usec last
//
// One request at a time. Add, remove, set and unknown requests register their
// result in S_EXEC; remaining in S_FINAL after one deadline RAM read; check in
// S_FINAL after a scan reading the deadline RAM one slot per cycle while no expired
// report is held. The next request is accepted once the final result is registered.
// Reset (rst, synchronous) empties the table; the deadline RAM is not cleared,
// an entry is read only while its slot is armed and arming writes it.
// A stalled response holds the sequencer (the scan waits on an expired slot);
// the next request is accepted once the sequencer is back in idle, even while
// the last response still waits in the output register.
module deadline_timer_table
  import dtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ID_W-1:0]   timer_id,
  input  logic [SEC_W-1:0]  now_sec,
  input  logic [USEC_W-1:0] now_usec,
  input  logic [SEC_W-1:0]  interval_sec,
  input  logic [USEC_W-1:0] interval_usec,
  output logic              resp_valid,
  input  logic              resp_stall,
  output logic [KIND_W-1:0] resp_kind,
  output logic [ID_W-1:0]   slot_id,
  output logic [SEC_W-1:0]  time_sec,
  output logic [USEC_W-1:0] time_usec,
  output logic              last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,  // waiting for a request
    S_EXEC  = 4'b0010,  // single-result requests; starts the RAM read otherwise
    S_SCAN  = 4'b0100,  // check: one slot per cycle unless an expired report is held
    S_FINAL = 4'b1000   // wait time / remaining time result
  } state_t;

  state_t state, state_next;

  // latched request
  logic [REQ_W-1:0]  op;
  logic [ID_W-1:0]   op_id;
  logic [SEC_W-1:0]  t_sec;
  logic [USEC_W-1:0] t_usec;
  logic [SEC_W-1:0]  ivl_sec;
  logic [USEC_W-1:0] ivl_usec;

  // slot flags (live in flops so reset can clear them)
  logic [NUM_SLOTS-1:0] slot_used, slot_armed;

  // scan state
  logic [SLOT_W-1:0] scan_idx, scan_idx_next;
  logic              any, any_next;
  logic [SEC_W-1:0]  min_sec, min_sec_next;
  logic [USEC_W-1:0] min_usec, min_usec_next;

  // deadline RAM
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [DL_W-1:0]   ram_wdata, ram_rdata;
  logic [SEC_W-1:0]  rd_sec;
  logic [USEC_W-1:0] rd_usec;

  logic req_accept;
  logic out_free;
  logic push;
  logic [KIND_W-1:0] p_kind;
  logic [ID_W-1:0]   p_slot;
  logic [SEC_W-1:0]  p_sec;
  logic [USEC_W-1:0] p_usec;
  logic              p_last;

  logic [SLOT_W-1:0] idx;
  logic              id_ok;
  logic              do_update;

  // lowest free slot
  logic [SLOT_W-1:0] free_idx;
  logic              free_found;

  // set: now + interval
  logic [USEC_W:0]   usum;
  logic              ucarry;
  logic [USEC_W-1:0] set_usec;
  logic [SEC_W:0]    ssum;
  logic [SEC_W-1:0]  set_sec;

  // scan evaluation
  logic scan_ok, scan_exp, scan_hold, scan_less;

  // shared deadline-minus-now unit
  logic              fin_check, fin_have, fin_passed, fin_borrow;
  logic [SEC_W-1:0]  dl_sec, diff_sec;
  logic [USEC_W-1:0] dl_usec, diff_usec;

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_free   = !resp_valid || !resp_stall;

  assign idx   = SLOT_W'(op_id);
  assign id_ok = (32'(op_id) < 32'(NUM_SLOTS));

  assign rd_sec  = ram_rdata[DL_W-1:USEC_W];
  assign rd_usec = ram_rdata[USEC_W-1:0];

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_idx   = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // microseconds carry into seconds, seconds saturate
  assign usum     = {1'b0, t_usec} + {1'b0, ivl_usec};
  assign ucarry   = (usum >= {1'b0, USEC_PER_SEC});
  assign set_usec = ucarry ? USEC_W'(usum - {1'b0, USEC_PER_SEC}) : usum[USEC_W-1:0];
  assign ssum     = {1'b0, t_sec} + {1'b0, ivl_sec} + (SEC_W + 1)'(ucarry);
  assign set_sec  = ssum[SEC_W] ? SEC_MAX : ssum[SEC_W-1:0];
  assign ram_wdata = {set_sec, set_usec};

  // scan: RAM data belongs to scan_idx
  assign scan_ok   = slot_used[scan_idx] && slot_armed[scan_idx];
  assign scan_exp  = scan_ok && ({rd_sec, rd_usec} <= {t_sec, t_usec});
  assign scan_less = {rd_sec, rd_usec} < {min_sec, min_usec};
  assign scan_hold = scan_exp && !out_free;

  // final result: earliest deadline for check, addressed slot for remaining
  assign fin_check  = (op == REQ_CHECK);
  assign fin_have   = fin_check ? any : (id_ok && slot_used[idx] && slot_armed[idx]);
  assign dl_sec     = fin_check ? min_sec  : rd_sec;
  assign dl_usec    = fin_check ? min_usec : rd_usec;
  assign fin_passed = ({dl_sec, dl_usec} <= {t_sec, t_usec});
  assign fin_borrow = (dl_usec < t_usec);
  assign diff_usec  = fin_borrow
                    ? USEC_W'({1'b0, dl_usec} + {1'b0, USEC_PER_SEC} - {1'b0, t_usec})
                    : dl_usec - t_usec;
  assign diff_sec   = dl_sec - t_sec - SEC_W'(fin_borrow);

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    any_next      = any;
    min_sec_next  = min_sec;
    min_usec_next = min_usec;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx;
    push          = 1'b0;
    p_kind        = KIND_ACK;
    p_slot        = op_id;
    p_sec         = '0;
    p_usec        = '0;
    p_last        = 1'b1;
    do_update     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op)
          REQ_CHECK: begin
            ram_re        = 1'b1;
            ram_raddr     = '0;
            scan_idx_next = '0;
            any_next      = 1'b0;
            state_next    = S_SCAN;
          end
          REQ_REMAIN: begin
            ram_re     = 1'b1;
            state_next = S_FINAL;
          end
          default: begin
            if (out_free) begin
              push       = 1'b1;
              do_update  = 1'b1;
              state_next = S_IDLE;
              if (op == REQ_ADD) begin
                p_kind = free_found ? KIND_ACK : KIND_FULL;
                p_slot = free_found ? ID_W'(free_idx) : '0;
              end else if (op == REQ_SET) begin
                ram_we = id_ok && slot_used[idx];
              end else if (op != REQ_REMOVE) begin
                p_slot = '0;  // unknown request type
              end
            end
          end
        endcase
      end
      S_SCAN: begin
        if (!scan_hold) begin
          push   = scan_exp;
          p_kind = KIND_EXPIRED;
          p_slot = ID_W'(scan_idx);
          p_last = 1'b0;
          if (scan_ok && (!any || scan_less)) begin
            any_next      = 1'b1;
            min_sec_next  = rd_sec;
            min_usec_next = rd_usec;
          end
          if (scan_idx == SLOT_W'(NUM_SLOTS - 1)) begin
            state_next = S_FINAL;
          end else begin
            ram_re        = 1'b1;
            ram_raddr     = scan_idx + 1'b1;
            scan_idx_next = scan_idx + 1'b1;
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
          p_kind     = fin_have ? KIND_WAIT : KIND_NONE;
          p_slot     = fin_check ? '0 : op_id;
          if (fin_have && !fin_passed) begin
            p_sec  = diff_sec;
            p_usec = diff_usec;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_used  <= '0;
      slot_armed <= '0;
      resp_valid <= 1'b0;
      scan_idx   <= '0;
      any        <= 1'b0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      any      <= any_next;
      if (push) begin
        resp_valid <= 1'b1;
      end else if (!resp_stall) begin
        resp_valid <= 1'b0;
      end
      if (do_update) begin
        if (op == REQ_ADD && free_found) begin
          slot_used[free_idx]  <= 1'b1;
          slot_armed[free_idx] <= 1'b0;
        end else if (op == REQ_REMOVE && id_ok) begin
          slot_used[idx]  <= 1'b0;
          slot_armed[idx] <= 1'b0;
        end else if (op == REQ_SET && id_ok && slot_used[idx]) begin
          slot_armed[idx] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_accept) begin
      op       <= req_type;
      op_id    <= timer_id;
      t_sec    <= now_sec;
      t_usec   <= clamp_usec(now_usec);
      ivl_sec  <= interval_sec;
      ivl_usec <= clamp_usec(interval_usec);
    end
    min_sec  <= min_sec_next;
    min_usec <= min_usec_next;
    if (push) begin
      resp_kind <= p_kind;
      slot_id   <= p_slot;
      time_sec  <= p_sec;
      time_usec <= p_usec;
      last      <= p_last;
    end
  end

  dtt_ram #(
    .WIDTH(DL_W),
    .DEPTH(NUM_SLOTS)
  ) u_deadline_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_armed_used: assert property (@(posedge clk) disable iff (rst)
    (slot_armed & ~slot_used) == '0)
    else $error("armed slot not in use");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> (state == S_EXEC))
    else $error("accepted request not executed");

  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && scan_hold |=> (state == S_SCAN) && $stable(scan_idx))
    else $error("scan advanced while expired report blocked");

  a_expired_not_last: assert property (@(posedge clk) disable iff (rst)
    resp_valid && (resp_kind == KIND_EXPIRED) |-> !last)
    else $error("expired report marked last");

endmodule
